// ----- sv/sha1md_pkg.sv -----
// Package for the SHA-1 message digest block: beat types, FSM and block-mode
// enums, initial hash and round constants.
// No dependencies.
`default_nettype none

package sha1md_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned BLK_WORDS   = 16;
    localparam logic [6:0]  ROUND_LAST  = 7'd79;
    localparam logic [6:0]  SCHED_FIRST = 7'd16;
    localparam logic [6:0]  LOAD_LAST   = 7'd5;
    localparam logic [2:0]  DIGEST_LAST = 3'd4;
    localparam logic [3:0]  LEN_HI_IDX  = 4'd14;
    localparam logic [3:0]  LEN_LO_IDX  = 4'd15;
    localparam logic [5:0]  POS_LAST    = 6'd63;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_ORD   = 7'b0100000,
        S_OSEND = 7'b1000000
    } state_t;

    // FULL: data block; PAD: last block with length; OVF: padded block
    // without length; LEN: length-only block after OVF
    typedef enum logic [1:0] {
        MODE_FULL = 2'd0,
        MODE_PAD  = 2'd1,
        MODE_OVF  = 2'd2,
        MODE_LEN  = 2'd3
    } blk_mode_t;

    function automatic logic [31:0] hash_init(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] place_byte(input logic [31:0] acc,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  b);
        logic [31:0] v;
        unique case (lane)
            2'd0:    v = {b, 24'h0};
            2'd1:    v = acc | {8'h0, b, 16'h0};
            2'd2:    v = acc | {16'h0, b, 8'h0};
            default: v = acc | {24'h0, b};
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sha1_message_digest.sv -----
// SHA-1 message digest over a byte stream, top level.
// Depends on sha1md_pkg.
//
//  channel | ports                     | direction | beat
//  s_      | s_valid s_ready s_data    | in        | one byte and/or end marker
//  m_      | m_valid m_ready m_data    | out       | one digest word, 5 per message
//
// Each byte beat is written to the block-word memory; the 64th byte of a block starts
// compression (hash load, 80 rounds, hash update), one round per cycle through
// the block-word and hash memories.
// End of message: pad setup, one or two compressed blocks, then a read and a send
// state per digest word, each send held until m_ready. Input is taken only when idle.
// Reset is synchronous, active low; no memory clearing pass is needed.
`default_nettype none

module sha1_message_digest (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire sha1md_pkg::in_beat_t  s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output sha1md_pkg::out_beat_t      m_data
);

    sha1md_pkg::state_t    state_reg, state_next;
    sha1md_pkg::blk_mode_t mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        end_pend_reg, end_pend_next;
    logic        fresh_reg, fresh_next;
    logic [63:0] msg_bits_reg, msg_bits_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pad_word_reg, pad_word_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] sched_reg [sha1md_pkg::BLK_WORDS];
    logic [31:0] sched_next [sha1md_pkg::BLK_WORDS];

    logic [31:0] bw_mem [sha1md_pkg::BLK_WORDS];
    logic        bw_we, bw_re;
    logic [3:0]  bw_waddr, bw_raddr;
    logic [31:0] bw_wdata, bw_rdata_reg;

    logic [31:0] hv_mem [sha1md_pkg::HASH_WORDS];
    logic        hv_we, hv_re;
    logic [2:0]  hv_waddr, hv_raddr, hv_ridx_reg;
    logic [31:0] hv_wdata, hv_rdata_reg;

    logic [5:0]  pos;
    logic        accept;
    logic [31:0] hval;
    logic [3:0]  widx;
    logic [31:0] blk_word, w_sel, f_val, k_val, t_val;

    assign pos    = msg_bits_reg[8:3];
    assign accept = s_valid && s_ready;
    assign hval   = fresh_reg ? sha1md_pkg::hash_init(hv_ridx_reg) : hv_rdata_reg;
    assign widx   = cnt_reg[3:0];

    assign s_ready             = (state_reg == sha1md_pkg::S_IDLE);
    assign m_valid             = (state_reg == sha1md_pkg::S_OSEND);
    assign m_data.digest_word  = hv_rdata_reg;
    assign m_data.word_index   = out_idx_reg;
    assign m_data.last_word    = (out_idx_reg == sha1md_pkg::DIGEST_LAST);

    // block word as seen by rounds 0..15, padding applied on the fly
    always_comb begin
        blk_word = 32'h0;
        unique case (mode_reg)
            sha1md_pkg::MODE_FULL: blk_word = bw_rdata_reg;
            sha1md_pkg::MODE_PAD, sha1md_pkg::MODE_OVF: begin
                if (widx < pad_idx_reg) begin
                    blk_word = bw_rdata_reg;
                end else if (widx == pad_idx_reg) begin
                    blk_word = pad_word_reg;
                end else if (mode_reg == sha1md_pkg::MODE_PAD
                             && widx == sha1md_pkg::LEN_HI_IDX) begin
                    blk_word = msg_bits_reg[63:32];
                end else if (mode_reg == sha1md_pkg::MODE_PAD
                             && widx == sha1md_pkg::LEN_LO_IDX) begin
                    blk_word = msg_bits_reg[31:0];
                end
            end
            default: begin
                if (widx == sha1md_pkg::LEN_HI_IDX) begin
                    blk_word = msg_bits_reg[63:32];
                end else if (widx == sha1md_pkg::LEN_LO_IDX) begin
                    blk_word = msg_bits_reg[31:0];
                end
            end
        endcase
    end

    always_comb begin
        logic [31:0] x;
        x = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_sel = (cnt_reg < sha1md_pkg::SCHED_FIRST) ? blk_word : {x[30:0], x[31]};
    end

    always_comb begin
        if (cnt_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K0;
        end else if (cnt_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K1;
        end else if (cnt_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_sel;
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cnt_next      = cnt_reg;
        end_pend_next = end_pend_reg;
        fresh_next    = fresh_reg;
        msg_bits_next = msg_bits_reg;
        acc_next      = acc_reg;
        pad_word_next = pad_word_reg;
        pad_idx_next  = pad_idx_reg;
        out_idx_next  = out_idx_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        sched_next    = sched_reg;
        bw_we         = 1'b0;
        bw_waddr      = pos[5:2];
        bw_wdata      = sha1md_pkg::place_byte(acc_reg, pos[1:0], s_data.data_byte);
        bw_re         = 1'b0;
        bw_raddr      = 4'd0;
        hv_we         = 1'b0;
        hv_waddr      = cnt_reg[2:0] - 3'd1;
        hv_wdata      = hval + a_reg;
        hv_re         = 1'b0;
        hv_raddr      = cnt_reg[2:0];

        unique case (state_reg)
            sha1md_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_data.has_byte) begin
                        bw_we         = 1'b1;
                        acc_next      = bw_wdata;
                        msg_bits_next = msg_bits_reg + 64'd8;
                    end
                    if (s_data.has_byte && pos == sha1md_pkg::POS_LAST) begin
                        state_next    = sha1md_pkg::S_LOAD;
                        mode_next     = sha1md_pkg::MODE_FULL;
                        cnt_next      = 7'd0;
                        end_pend_next = s_data.end_of_message;
                    end else if (s_data.end_of_message) begin
                        state_next = sha1md_pkg::S_PAD;
                    end
                end
            end
            sha1md_pkg::S_PAD: begin
                pad_word_next = sha1md_pkg::place_byte(acc_reg, pos[1:0],
                                                       sha1md_pkg::PAD_BYTE);
                pad_idx_next  = pos[5:2];
                mode_next     = (pos[5:3] == 3'b111) ? sha1md_pkg::MODE_OVF
                                                     : sha1md_pkg::MODE_PAD;
                end_pend_next = 1'b0;
                cnt_next      = 7'd0;
                state_next    = sha1md_pkg::S_LOAD;
            end
            sha1md_pkg::S_LOAD: begin
                hv_re = (cnt_reg < sha1md_pkg::LOAD_LAST);
                if (cnt_reg != 7'd0) begin
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                    e_next = hval;
                end
                if (cnt_reg == sha1md_pkg::LOAD_LAST) begin
                    bw_re      = 1'b1;
                    bw_raddr   = 4'd0;
                    cnt_next   = 7'd0;
                    state_next = sha1md_pkg::S_ROUND;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::S_ROUND: begin
                bw_re    = (cnt_reg < 7'd15);
                bw_raddr = widx + 4'd1;
                a_next   = t_val;
                b_next   = a_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                d_next   = c_reg;
                e_next   = d_reg;
                for (int i = 0; i < 15; i++) begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[15] = w_sel;
                if (cnt_reg == sha1md_pkg::ROUND_LAST) begin
                    cnt_next   = 7'd0;
                    state_next = sha1md_pkg::S_FIN;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::S_FIN: begin
                hv_re = (cnt_reg < sha1md_pkg::LOAD_LAST);
                if (cnt_reg != 7'd0) begin
                    hv_we  = 1'b1;
                    a_next = b_reg;
                    b_next = c_reg;
                    c_next = d_reg;
                    d_next = e_reg;
                end
                if (cnt_reg == sha1md_pkg::LOAD_LAST) begin
                    fresh_next = 1'b0;
                    cnt_next   = 7'd0;
                    unique case (mode_reg)
                        sha1md_pkg::MODE_FULL: begin
                            state_next = end_pend_reg ? sha1md_pkg::S_PAD
                                                      : sha1md_pkg::S_IDLE;
                        end
                        sha1md_pkg::MODE_OVF: begin
                            mode_next  = sha1md_pkg::MODE_LEN;
                            state_next = sha1md_pkg::S_LOAD;
                        end
                        default: begin
                            out_idx_next = 3'd0;
                            state_next   = sha1md_pkg::S_ORD;
                        end
                    endcase
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            sha1md_pkg::S_ORD: begin
                hv_re      = 1'b1;
                hv_raddr   = out_idx_reg;
                state_next = sha1md_pkg::S_OSEND;
            end
            sha1md_pkg::S_OSEND: begin
                if (m_ready) begin
                    if (out_idx_reg == sha1md_pkg::DIGEST_LAST) begin
                        fresh_next    = 1'b1;
                        msg_bits_next = 64'd0;
                        out_idx_next  = 3'd0;
                        state_next    = sha1md_pkg::S_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = sha1md_pkg::S_ORD;
                    end
                end
            end
            default: begin
                state_next = sha1md_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1md_pkg::S_IDLE;
            mode_reg     <= sha1md_pkg::MODE_FULL;
            cnt_reg      <= 7'd0;
            end_pend_reg <= 1'b0;
            fresh_reg    <= 1'b1;
            msg_bits_reg <= 64'd0;
            out_idx_reg  <= 3'd0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            end_pend_reg <= end_pend_next;
            fresh_reg    <= fresh_next;
            msg_bits_reg <= msg_bits_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        pad_word_reg <= pad_word_next;
        pad_idx_reg  <= pad_idx_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        e_reg        <= e_next;
        sched_reg    <= sched_next;
    end

    // block word memory
    always_ff @(posedge aclk) begin
        if (bw_we) begin
            bw_mem[bw_waddr] <= bw_wdata;
        end
        if (bw_re) begin
            bw_rdata_reg <= bw_mem[bw_raddr];
        end
    end

    // chaining value memory; reads as initial constants while fresh
    always_ff @(posedge aclk) begin
        if (hv_we) begin
            hv_mem[hv_waddr] <= hv_wdata;
        end
        if (hv_re) begin
            hv_rdata_reg <= hv_mem[hv_raddr];
            hv_ridx_reg  <= hv_raddr;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sha1_message_digest_tb.sv -----
// Testbench for sha1_message_digest: streams message bytes and end markers and
// checks every digest word against a SHA-1 model that runs inside this bench.
// Depends on sha1md_pkg and the sha1_message_digest RTL.
`timescale 1ns / 1ps

module sha1_message_digest_tb;

    localparam int unsigned ITEM_TARGET = 280;
    localparam int unsigned QUIET_TAIL  = 40;
    localparam int unsigned WDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 200;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha1md_pkg::in_beat_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha1md_pkg::out_beat_t m_data;

    logic        idle_on    = 1'b1;
    int unsigned ready_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned beats_sent = 0;
    int unsigned error_count = 0;

    logic [31:0] hash_state [5];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bits;
    sha1md_pkg::out_beat_t expected_digest_q [$];

    sha1_message_digest dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- SHA-1 prediction ----------------

    task automatic restart_message();
        hash_state[0] = IV0;
        hash_state[1] = IV1;
        hash_state[2] = IV2;
        hash_state[3] = IV3;
        hash_state[4] = IV4;
        msg_bits = '0;
    endtask

    task automatic sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int r;
        for (r = 0; r < 16; r++) w[r] = msg_block[r];
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                w[r % 16] = {x[30:0], x[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endtask

    // big-endian lane; the first byte of a word clears the rest of it
    task automatic pack_byte(input logic [5:0] pos, input logic [7:0] b);
        logic [31:0] lane_val;
        lane_val = {24'h0, b} << (8 * (3 - pos[1:0]));
        if (pos[1:0] == 2'd0) msg_block[pos[5:2]] = lane_val;
        else msg_block[pos[5:2]] |= lane_val;
    endtask

    task automatic absorb_beat(input sha1md_pkg::in_beat_t bt);
        logic [5:0] pos;
        int j;
        sha1md_pkg::out_beat_t ob;
        if (bt.has_byte) begin
            pos = msg_bits[8:3];
            pack_byte(pos, bt.data_byte);
            msg_bits += 64'd8;
            if (pos == 6'd63) sha1_compress();
        end
        if (bt.end_of_message) begin
            pos = msg_bits[8:3];
            pack_byte(pos, 8'h80);
            for (j = pos[5:2] + 1; j < 16; j++) msg_block[j] = '0;
            if (pos >= 6'd56) begin
                sha1_compress();
                for (j = 0; j < 14; j++) msg_block[j] = '0;
            end
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            sha1_compress();
            for (j = 0; j < 5; j++) begin
                ob.digest_word = hash_state[j];
                ob.word_index  = 3'(j);
                ob.last_word   = (j == 4);
                expected_digest_q.push_back(ob);
            end
            restart_message();
        end
    endtask

    // ---------------- stimulus ----------------

    task automatic send_beat(input logic [7:0] b, input logic hb, input logic eom);
        sha1md_pkg::in_beat_t bt;
        bt.data_byte      = b;
        bt.has_byte       = hb;
        bt.end_of_message = eom;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= bt;
        do @(posedge aclk); while (!s_ready);
        absorb_beat(bt);
        beats_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        int unsigned i;
        logic bare_end;
        bare_end = (len == 0) || ($urandom_range(0, 1) == 0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, !bare_end && (i == len - 1));
        end
        if (bare_end) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_idle_beats();
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_abc();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
    endtask

    // pad fits, pad spills into a length-only block, exact full block
    task automatic test_block_boundaries();
        send_message(55);
        send_message(56);
        send_message(64);
    endtask

    task automatic test_random_messages();
        int unsigned len;
        while (beats_sent < ITEM_TARGET) begin
            if (beats_sent >= ITEM_TARGET - QUIET_TAIL) idle_on <= 1'b0;
            if ($urandom_range(0, 4) == 0) len = $urandom_range(50, 70);
            else len = $urandom_range(0, 20);
            if (len > ITEM_TARGET - beats_sent) len = ITEM_TARGET - beats_sent;
            send_message(len);
        end
    endtask

    // ---------------- sink, checker, watchdog ----------------

    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sha1md_pkg::out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (expected_digest_q.size() == 0) begin
                $error("unexpected digest beat: word %h index %0d", m_data.digest_word,
                       m_data.word_index);
                error_count++;
            end else begin
                exp_beat = expected_digest_q.pop_front();
                if (m_data.digest_word !== exp_beat.digest_word) begin
                    $error("digest_word: expected %h, actual %h", exp_beat.digest_word,
                           m_data.digest_word);
                    error_count++;
                end
                if (m_data.word_index !== exp_beat.word_index) begin
                    $error("word_index: expected %0d, actual %0d", exp_beat.word_index,
                           m_data.word_index);
                    error_count++;
                end
                if (m_data.last_word !== exp_beat.last_word) begin
                    $error("last_word: expected %0b, actual %0b", exp_beat.last_word,
                           m_data.last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        restart_message();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_message();
        test_idle_beats();
        test_abc();
        test_byte_extremes();
        test_block_boundaries();
        test_random_messages();
        s_valid <= 1'b0;
        while (expected_digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
